### hdl/atou_pkg.sv
// shared types and constants for the ascii to unsigned parser
`timescale 1ns / 1ps
`default_nettype none

package atou_pkg;

    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 5;
    localparam int DIGIT_W = 4;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;

    // radix codes
    localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;
    localparam logic [DIGIT_W-1:0] HEX_LETTER_OFS = 4'd10;

    // parse phase of the back end
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_ZERO,
        PH_DIGITS,
        PH_DRAIN
    } t_phase;

    // classified character as it travels through the queue
    typedef struct packed {
        logic               is_nul;
        logic               is_blank;
        logic               is_zero;
        logic               is_x;
        logic               is_hex;
        logic [DIGIT_W-1:0] digit;
    } t_char_class;

endpackage

`default_nettype wire

### hdl/atou_front.sv
// front end: character classifier and two-entry request queue
`timescale 1ns / 1ps
`default_nettype none

module atou_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [atou_pkg::CHAR_W-1:0] i_char,
    output logic                       o_q_valid,
    output atou_pkg::t_char_class      o_q_item,
    input  wire                        i_q_pop
);
    import atou_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_char_class            cls;
    t_char_class            r_slot [DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]       r_count,  n_count;
    logic                   push;
    logic                   is_dec, is_lc, is_uc;

    // classify
    always_comb begin
        is_dec = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        is_lc  = (i_char >= CH_LC_A) && (i_char <= CH_LC_F);
        is_uc  = (i_char >= CH_UC_A) && (i_char <= CH_UC_F);
        cls.is_nul   = (i_char == CH_NUL);
        cls.is_blank = (i_char == CH_SPACE) || (i_char == CH_TAB);
        cls.is_zero  = (i_char == CH_ZERO);
        cls.is_x     = (i_char == CH_LC_X) || (i_char == CH_UC_X);
        cls.is_hex   = is_dec || is_lc || is_uc;
        priority if (is_lc) begin
            cls.digit = DIGIT_W'(i_char - CH_LC_A) + HEX_LETTER_OFS;
        end else if (is_uc) begin
            cls.digit = DIGIT_W'(i_char - CH_UC_A) + HEX_LETTER_OFS;
        end else begin
            cls.digit = DIGIT_W'(i_char - CH_ZERO);
        end
    end

    assign o_ready   = (r_count != CNT_W'(DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push    ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_q_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + CNT_W'(push) - CNT_W'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cls;
        end
    end

endmodule

`default_nettype wire

### hdl/atou_back.sv
// back end: parse state machine, multiply-accumulate and result register
`timescale 1ns / 1ps
`default_nettype none

module atou_back #(
    parameter int VALUE_BITS  = 32,
    parameter int OFFSET_BITS = 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  [atou_pkg::BASE_W-1:0] i_number_base,
    input  wire                         i_q_valid,
    input  atou_pkg::t_char_class       i_q_item,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [VALUE_BITS-1:0]       o_value,
    output logic [OFFSET_BITS-1:0]      o_offset,
    output logic [atou_pkg::BASE_W-1:0] o_base,
    output logic                        o_wrapped
);
    import atou_pkg::*;

    localparam int MUL_W = VALUE_BITS + BASE_W;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    t_phase                  r_phase, n_phase;
    logic [VALUE_BITS-1:0]   r_acc,   n_acc;
    logic [BASE_W-1:0]       r_base,  n_base;
    logic [OFFSET_BITS-1:0]  r_off,   n_off;
    logic                    r_ovf,   n_ovf;
    logic                    r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0]   r_out_value;
    logic [OFFSET_BITS-1:0]  r_out_offset;
    logic [BASE_W-1:0]       r_out_base;
    logic                    r_out_wrapped;

    logic                    pop, emit, do_take, digit_ok, wrap;
    logic [BASE_W-1:0]       base_sel;
    logic [VALUE_BITS-1:0]   acc_in;
    logic [OFFSET_BITS-1:0]  off_in;
    logic                    ovf_in;
    logic [MUL_W-1:0]        mac;

    // a result slot that is empty or being emptied lets the next request through
    assign pop     = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = pop;

    always_comb begin
        // radix and running values seen by the digit step
        unique case (r_phase)
            PH_SKIP:   base_sel = (i_number_base == BASE_AUTO) ? BASE_DEC : i_number_base;
            PH_ZERO:   base_sel = BASE_DEC;
            default:   base_sel = r_base;
        endcase
        acc_in   = (r_phase == PH_SKIP) ? '0   : r_acc;
        ovf_in   = (r_phase == PH_SKIP) ? 1'b0 : r_ovf;
        off_in   = (r_phase == PH_ZERO) ? sat_inc(r_off) : r_off;
        digit_ok = i_q_item.is_hex && ({1'b0, i_q_item.digit} < base_sel);
        mac      = MUL_W'(acc_in) * MUL_W'(base_sel) + MUL_W'(i_q_item.digit);
        wrap     = |mac[MUL_W-1:VALUE_BITS];

        n_phase = r_phase;
        n_acc   = r_acc;
        n_base  = r_base;
        n_off   = r_off;
        n_ovf   = r_ovf;
        emit    = 1'b0;
        do_take = 1'b0;

        if (pop) begin
            unique case (r_phase)
                PH_SKIP: begin
                    if (i_q_item.is_blank) begin
                        n_off = sat_inc(r_off);
                    end else if (i_number_base == BASE_AUTO && i_q_item.is_zero) begin
                        n_acc   = '0;
                        n_ovf   = 1'b0;
                        n_phase = PH_ZERO;
                    end else begin
                        do_take = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (i_q_item.is_x) begin
                        n_base  = BASE_HEX;
                        n_off   = sat_inc(sat_inc(r_off));
                        n_phase = PH_DIGITS;
                    end else begin
                        do_take = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    do_take = 1'b1;
                end
                PH_DRAIN: begin
                    if (i_q_item.is_nul) begin
                        n_phase = PH_SKIP;
                        n_acc   = '0;
                        n_base  = '0;
                        n_off   = '0;
                        n_ovf   = 1'b0;
                    end
                end
            endcase
        end

        if (do_take) begin
            if (digit_ok) begin
                n_acc   = mac[VALUE_BITS-1:0];
                n_ovf   = ovf_in | wrap;
                n_off   = sat_inc(off_in);
                n_base  = base_sel;
                n_phase = PH_DIGITS;
            end else begin
                emit = 1'b1;
                if (i_q_item.is_nul) begin
                    n_phase = PH_SKIP;
                    n_acc   = '0;
                    n_base  = '0;
                    n_off   = '0;
                    n_ovf   = 1'b0;
                end else begin
                    n_phase = PH_DRAIN;
                end
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_acc       <= '0;
            r_base      <= '0;
            r_off       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_base      <= n_base;
            r_off       <= n_off;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_value   <= acc_in;
            r_out_offset  <= off_in;
            r_out_base    <= base_sel;
            r_out_wrapped <= ovf_in;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_value   = r_out_value;
    assign o_offset  = r_out_offset;
    assign o_base    = r_out_base;
    assign o_wrapped = r_out_wrapped;

endmodule

`default_nettype wire

### hdl/ascii_to_unsigned_parser_unit.sv
// top level of the ascii to unsigned parser: base register, front and back ends
// throughput: one character per clock unless a result waits untaken; the back end runs one multiply-add per cycle
// result: the back end registers it in the output slot when it pops the terminating character
// the two-entry queue lets the front take up to two more characters while a result waits
// reset: synchronous active low; clears parse phase, counters, queue and base (auto)
`timescale 1ns / 1ps
`default_nettype none

module ascii_to_unsigned_parser_unit #(
    parameter int VALUE_BITS  = 32,
    parameter int OFFSET_BITS = 8,
    parameter int DATA_W      = ((VALUE_BITS + OFFSET_BITS + atou_pkg::BASE_W + 1 + 7) / 8) * 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // character requests
    input  wire                         i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire  [atou_pkg::CHAR_W-1:0] i_s_axis_tdata,   // char_code
    // parse results
    output logic                        o_m_axis_tvalid,
    input  wire                         i_m_axis_tready,
    output logic [DATA_W-1:0]           o_m_axis_tdata,   // parsed_value, end_offset, used_base, wrapped, zero pad
    // base register
    input  wire                         i_cfg_wr_en,
    input  wire  [atou_pkg::BASE_W-1:0] i_cfg_wr_data     // number_base
);
    import atou_pkg::*;

    // number_base register, zero means auto-detect
    logic [BASE_W-1:0]      r_number_base;

    // queue between front and back
    logic                   q_valid;
    logic                   q_pop;
    t_char_class            q_item;

    // result fields
    logic [VALUE_BITS-1:0]  res_value;
    logic [OFFSET_BITS-1:0] res_offset;
    logic [BASE_W-1:0]      res_base;
    logic                   res_wrapped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_AUTO;
        end else if (i_cfg_wr_en) begin
            r_number_base <= i_cfg_wr_data;
        end
    end

    // front: classify each character and queue it
    atou_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_char    (i_s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    // back: walk the parse phases and hold the result until taken
    atou_back #(
        .VALUE_BITS  (VALUE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_number_base (r_number_base),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_value       (res_value),
        .o_offset      (res_offset),
        .o_base        (res_base),
        .o_wrapped     (res_wrapped)
    );

    // pack fields from the lowest bit up, zero fill to whole bytes
    assign o_m_axis_tdata = DATA_W'({res_wrapped, res_base, res_offset, res_value});

endmodule

`default_nettype wire

### hdl/atou_checker.sv
// port-level checker for the parser, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module atou_checker #(
    parameter int VALUE_BITS  = 32,
    parameter int OFFSET_BITS = 8,
    parameter int DATA_W      = 48
) (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              o_m_axis_tvalid,
    input wire              i_m_axis_tready,
    input wire [DATA_W-1:0] o_m_axis_tdata
);
    import atou_pkg::*;

    localparam int BASE_LSB = VALUE_BITS + OFFSET_BITS;

    // reset empties the result slot
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a result is never dropped while stalled
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its fields
    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // the reported radix is never zero
    a_base_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[BASE_LSB +: BASE_W] != BASE_AUTO))
        else $error("used base is zero");

endmodule

bind ascii_to_unsigned_parser_unit atou_checker #(
    .VALUE_BITS  (VALUE_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .DATA_W      (DATA_W)
) u_atou_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
